// ===== rtl/uera_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uera_pkg: shared types and constants of the echo ranging averager
// Holds the configuration record, the microcode control word, the status
// record read back by the sequencer, the result record and the field widths.
// ----------------------------------------------------------------------------
package uera_pkg;

  // Field widths of the items and registers.
  localparam int CNT_W     = 8;
  localparam int AVG_W     = 14;
  localparam int SUM_W     = 21;
  localparam int SUMX_W    = SUM_W + 1;
  localparam int SUM_MAX   = 2097151;
  localparam int TMO_W     = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int UPC_W     = 6;

  // Default width of the tick counter.
  localparam int TICK_W_DEF = 16;

  // Echo width to Q4 centimetres: floor(width * 281 / 1024).
  localparam int DIST_MULT  = 281;
  localparam int DIST_MUL_W = 9;
  localparam int DIST_SHIFT = 10;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAUSE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DIST  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DIST  = 3'd5;

  // Register values after reset.
  localparam logic [CNT_W-1:0] RST_TRIG_LOW  = 8'd2;
  localparam logic [CNT_W-1:0] RST_TRIG_HIGH = 8'd10;
  localparam logic [TMO_W-1:0] RST_TIMEOUT   = 16'd30000;
  localparam logic [TMO_W-1:0] RST_PAUSE     = 16'd10000;
  localparam logic [AVG_W-1:0] RST_MIN_DIST  = 14'd32;
  localparam logic [AVG_W-1:0] RST_MAX_DIST  = 14'd6400;

  typedef struct packed {
    logic [CNT_W-1:0] trig_low;
    logic [CNT_W-1:0] trig_high;
    logic [TMO_W-1:0] timeout;
    logic [TMO_W-1:0] pause;
    logic [AVG_W-1:0] min_dist;
    logic [AVG_W-1:0] max_dist;
  } cfg_t;

  // Measurement phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TLOW  = 6'b000010,
    PH_THIGH = 6'b000100,
    PH_RISE  = 6'b001000,
    PH_FALL  = 6'b010000,
    PH_PAUSE = 6'b100000
  } phase_t;

  // Tick counter operation of a microcode step.
  typedef enum logic [1:0] {
    T_HOLD,
    T_INC,
    T_CLR,
    T_ONE
  } tick_op_t;

  // Datapath operation of a microcode step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_RUN,
    OP_MUL,
    OP_ACCUM,
    OP_REM_DEC,
    OP_DIV_START,
    OP_REP_AVG,
    OP_REP_ERR,
    OP_PUSH
  } dp_op_t;

  // How the step counter moves on.
  typedef enum logic [1:0] {
    JK_NEXT,
    JK_COND,
    JK_DISPATCH
  } jump_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_FIRE,
    C_START,
    C_COUNT_ZERO,
    C_LOW_ZERO,
    C_GE_LOW,
    C_GE_HIGH,
    C_ECHO,
    C_GE_TMO,
    C_PAUSE_ZERO,
    C_GE_PAUSE,
    C_REM_NZ,
    C_VALID_ZERO,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    logic             in_rdy;
    tick_op_t         tick_op;
    logic             ph_we;
    phase_t           ph_val;
    dp_op_t           op;
    jump_t            jk;
    cond_t            cond;
    logic             inv;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    phase_t phase;
    logic   in_fire;
    logic   start;
    logic   count_zero;
    logic   low_zero;
    logic   ge_low;
    logic   ge_high;
    logic   echo;
    logic   ge_tmo;
    logic   pause_zero;
    logic   ge_pause;
    logic   rem_nz;
    logic   valid_zero;
    logic   div_busy;
    logic   out_full;
  } status_t;

  typedef struct packed {
    logic             trig;
    logic             busy;
    logic             done;
    logic             error;
    logic [AVG_W-1:0] avg;
    logic [CNT_W-1:0] cnt;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranging_averager_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_averager_top: averaging echo-pulse range finder
// One item per microsecond tick; a microcoded sequencer runs trigger, echo
// timing, range check and averaging, and one result leaves per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in_*      input      in_valid / in_ready        start_req, sample_count, echo_level
//  out_*     output     out_valid / out_ready      trig_level, busy_res, done_res,
//                                                  error, average_distance_q4,
//                                                  accepted_count
//  APB       config     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
//  The item that ends a run with accepted samples waits in the sequencer for
//  the 21-step divider that forms the mean to finish.
//  Reset is synchronous: the step counter returns to fetch, the phase goes
//  idle and the registers take their defaults.
//  The next item is taken while a result waits in the output register; the
//  sequencer holds at its emit step until that register frees.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging_averager_top #(
  parameter int TICK_COUNTER_WIDTH = uera_pkg::TICK_W_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_start_req,
  input  wire logic [uera_pkg::CNT_W-1:0]  in_sample_count,
  input  wire logic                        in_echo_level,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_trig_level,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic                             out_error,
  output logic      [uera_pkg::AVG_W-1:0]  out_average_distance_q4,
  output logic      [uera_pkg::CNT_W-1:0]  out_accepted_count,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uera_pkg::ADDR_W-1:0] paddr,
  input  wire logic [uera_pkg::DATA_W-1:0] pwdata,
  output logic      [uera_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import uera_pkg::*;

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;
  res_t    res;
  res_t    out_r;
  logic    out_valid_r, out_valid_nxt;
  logic    in_fire;
  logic    out_full;
  logic    push;

  assign in_ready = ctrl.in_rdy;
  assign in_fire  = in_valid & in_ready;
  assign out_full = out_valid_r & ~out_ready;
  assign push     = (ctrl.op == OP_PUSH);

  uera_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uera_dp #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .cfg             (cfg),
    .in_fire         (in_fire),
    .out_full        (out_full),
    .in_start_req    (in_start_req),
    .in_sample_count (in_sample_count),
    .in_echo_level   (in_echo_level),
    .status          (status),
    .res             (res)
  );

  uera_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // Output register: loaded by the push step, emptied by the consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_trig_level          = out_r.trig;
  assign out_busy_res            = out_r.busy;
  assign out_done_res            = out_r.done;
  assign out_error               = out_r.error;
  assign out_average_distance_q4 = out_r.avg;
  assign out_accepted_count      = out_r.cnt;

  // A push never lands on a result that is still waiting.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !out_valid_r)
    else $error("result pushed over a waiting result");

  // A reported result always finds the sequence stopped.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done) |-> !out_r.busy)
    else $error("done reported while the sequence is still running");

endmodule

`default_nettype wire

// ===== rtl/uera_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uera_div: restoring divider for the mean
// Divides the distance sum by the accepted count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module uera_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [uera_pkg::SUM_W-1:0] dividend,
  input  wire logic [uera_pkg::CNT_W-1:0] divisor,
  output logic                            busy,
  output logic [uera_pkg::SUM_W-1:0]      quotient
);
  import uera_pkg::*;

  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r;
  logic [SUM_W-1:0]     dvd_r;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       diff;
  logic                 ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted  = {rem_r, quo_r[SUM_W-1]};
    diff     = shifted - {1'b0, div_r};
    ge       = (shifted >= {1'b0, div_r});
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(SUM_W);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  // Step count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
      dvd_r <= dividend;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

  // A division is started only when the unit is free and the count is nonzero.
  a_div_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy && divisor != '0))
    else $error("divider started while busy or with a zero divisor");

  // The finished quotient and remainder rebuild the dividend.
  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (({8'b0, quo_r} * {21'b0, div_r} + {21'b0, rem_r}) == {8'b0, dvd_r}))
    else $error("divider result does not match its operands");

endmodule

`default_nettype wire

// ===== rtl/uera_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uera_cfg: configuration register file
// Six timing and range registers behind an APB-style port that never inserts wait states.
// ----------------------------------------------------------------------------
module uera_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uera_pkg::ADDR_W-1:0] paddr,
  input  wire logic [uera_pkg::DATA_W-1:0] pwdata,
  output logic      [uera_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output uera_pkg::cfg_t                   cfg
);
  import uera_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite & pready;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_TRIG_LOW:  cfg_nxt.trig_low  = pwdata[CNT_W-1:0];
        REG_TRIG_HIGH: cfg_nxt.trig_high = pwdata[CNT_W-1:0];
        REG_TIMEOUT:   cfg_nxt.timeout   = pwdata[TMO_W-1:0];
        REG_PAUSE:     cfg_nxt.pause     = pwdata[TMO_W-1:0];
        REG_MIN_DIST:  cfg_nxt.min_dist  = pwdata[AVG_W-1:0];
        REG_MAX_DIST:  cfg_nxt.max_dist  = pwdata[AVG_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_low  <= RST_TRIG_LOW;
      cfg_r.trig_high <= RST_TRIG_HIGH;
      cfg_r.timeout   <= RST_TIMEOUT;
      cfg_r.pause     <= RST_PAUSE;
      cfg_r.min_dist  <= RST_MIN_DIST;
      cfg_r.max_dist  <= RST_MAX_DIST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_TRIG_LOW:  prdata = DATA_W'(cfg_r.trig_low);
      REG_TRIG_HIGH: prdata = DATA_W'(cfg_r.trig_high);
      REG_TIMEOUT:   prdata = DATA_W'(cfg_r.timeout);
      REG_PAUSE:     prdata = DATA_W'(cfg_r.pause);
      REG_MIN_DIST:  prdata = DATA_W'(cfg_r.min_dist);
      REG_MAX_DIST:  prdata = DATA_W'(cfg_r.max_dist);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/uera_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uera_dp: measurement datapath
// Phase and tick registers, sample bookkeeping, distance multiplier, range
// check, saturating sum and the divider, all driven by the control word.
// ----------------------------------------------------------------------------
module uera_dp #(
  parameter int TICK_COUNTER_WIDTH = uera_pkg::TICK_W_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  uera_pkg::ctrl_t                 ctrl,
  input  uera_pkg::cfg_t                  cfg,
  input  wire logic                       in_fire,
  input  wire logic                       out_full,
  input  wire logic                       in_start_req,
  input  wire logic [uera_pkg::CNT_W-1:0] in_sample_count,
  input  wire logic                       in_echo_level,
  output uera_pkg::status_t               status,
  output uera_pkg::res_t                  res
);
  import uera_pkg::*;

  localparam int TW     = TICK_COUNTER_WIDTH;
  localparam int EXT_W  = (TW > TMO_W) ? TW : TMO_W;
  localparam int PROD_W = TW + DIST_MUL_W;
  localparam int D_W    = PROD_W - DIST_SHIFT;
  localparam int DC_W   = (D_W > AVG_W) ? D_W : AVG_W;

  phase_t           phase_r, phase_nxt;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] valid_r, valid_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [AVG_W-1:0] last_avg_r, last_avg_nxt;
  logic             rep_done_r, rep_done_nxt;
  logic             rep_err_r, rep_err_nxt;
  logic [CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic [D_W-1:0]   d_r;
  logic             in_start_r;
  logic [CNT_W-1:0] in_count_r;
  logic             in_echo_r;

  logic [TW-1:0]     tick_inc;
  logic              tick_max;
  logic [EXT_W-1:0]  tick_ext;
  logic [PROD_W-1:0] prod;
  logic [DC_W-1:0]   d_ext;
  logic              in_range;
  logic [SUMX_W-1:0] sum_add;
  logic              div_start;
  logic              div_busy;
  logic [SUM_W-1:0]  div_quo;

  // Saturating tick increment and the comparisons against the settings.
  assign tick_max = &tick_r;
  assign tick_inc = tick_max ? tick_r : tick_r + TW'(1);
  assign tick_ext = EXT_W'(tick_r);

  // Echo width to distance, registered before the range check.
  assign prod     = PROD_W'(tick_r) * PROD_W'(DIST_MULT);
  assign d_ext    = DC_W'(d_r);
  assign in_range = (d_ext >= DC_W'(cfg.min_dist)) && (d_ext <= DC_W'(cfg.max_dist));
  assign sum_add  = SUMX_W'(sum_r) + SUMX_W'(d_ext[AVG_W-1:0]);

  assign div_start = (ctrl.op == OP_DIV_START);

  uera_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (valid_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Next state of the control registers.
  always_comb begin
    phase_nxt    = ctrl.ph_we ? ctrl.ph_val : phase_r;
    rem_nxt      = rem_r;
    valid_nxt    = valid_r;
    sum_nxt      = sum_r;
    last_avg_nxt = last_avg_r;
    rep_done_nxt = rep_done_r;
    rep_err_nxt  = rep_err_r;
    rep_cnt_nxt  = rep_cnt_r;

    case (ctrl.tick_op)
      T_HOLD:  tick_nxt = tick_r;
      T_INC:   tick_nxt = tick_inc;
      T_CLR:   tick_nxt = '0;
      T_ONE:   tick_nxt = TW'(1);
      default: tick_nxt = tick_r;
    endcase

    if (in_fire) begin
      rep_done_nxt = 1'b0;
      rep_err_nxt  = 1'b0;
      rep_cnt_nxt  = '0;
    end

    case (ctrl.op)
      OP_LOAD_RUN: begin
        rem_nxt   = in_count_r;
        valid_nxt = '0;
        sum_nxt   = '0;
      end
      OP_ACCUM: begin
        if (in_range) begin
          valid_nxt = valid_r + CNT_W'(1);
          sum_nxt   = (sum_add > SUMX_W'(SUM_MAX)) ? SUM_W'(SUM_MAX) : sum_add[SUM_W-1:0];
        end
      end
      OP_REM_DEC: rem_nxt = rem_r - CNT_W'(1);
      OP_REP_AVG: begin
        last_avg_nxt = div_quo[AVG_W-1:0];
        rep_done_nxt = 1'b1;
        rep_cnt_nxt  = valid_r;
      end
      OP_REP_ERR: begin
        rep_done_nxt = 1'b1;
        rep_err_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      rem_r      <= '0;
      valid_r    <= '0;
      sum_r      <= '0;
      last_avg_r <= '0;
      rep_done_r <= 1'b0;
      rep_err_r  <= 1'b0;
      rep_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      rem_r      <= rem_nxt;
      valid_r    <= valid_nxt;
      sum_r      <= sum_nxt;
      last_avg_r <= last_avg_nxt;
      rep_done_r <= rep_done_nxt;
      rep_err_r  <= rep_err_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
    end
  end

  // Item capture and the registered distance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_start_r <= in_start_req;
      in_count_r <= in_sample_count;
      in_echo_r  <= in_echo_level;
    end
    if (ctrl.op == OP_MUL) begin
      d_r <= prod[PROD_W-1:DIST_SHIFT];
    end
  end

  // Flags for the sequencer's jumps.
  always_comb begin
    status.phase      = phase_r;
    status.in_fire    = in_fire;
    status.start      = in_start_r;
    status.count_zero = (in_count_r == '0);
    status.low_zero   = (cfg.trig_low == '0);
    status.ge_low     = (tick_ext >= EXT_W'(cfg.trig_low));
    status.ge_high    = (tick_ext >= EXT_W'(cfg.trig_high));
    status.echo       = in_echo_r;
    status.ge_tmo     = (tick_ext >= EXT_W'(cfg.timeout)) || tick_max;
    status.pause_zero = (cfg.pause == '0);
    status.ge_pause   = (tick_ext >= EXT_W'(cfg.pause));
    status.rem_nz     = (rem_r != '0);
    status.valid_zero = (valid_r == '0);
    status.div_busy   = div_busy;
    status.out_full   = out_full;
  end

  // Result of the item as it stands after its update.
  always_comb begin
    res.trig  = (phase_r == PH_THIGH);
    res.busy  = (phase_r != PH_IDLE);
    res.done  = rep_done_r;
    res.error = rep_err_r;
    res.avg   = (rep_done_r && !rep_err_r) ? last_avg_r : '0;
    res.cnt   = rep_cnt_r;
  end

  // An error report always comes with done.
  a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    rep_err_r |-> rep_done_r)
    else $error("error flag raised without done");

  // The tick counter rests at zero whenever no sequence is running.
  a_idle_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_r == '0))
    else $error("tick counter not cleared in idle phase");

endmodule

`default_nettype wire

// ===== rtl/uera_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uera_seq: microcode sequencer
// Step counter, control store and jump logic. Each step issues one control
// word; a jump is taken on a selected status flag or on the current phase.
// ----------------------------------------------------------------------------
module uera_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  uera_pkg::status_t status,
  output uera_pkg::ctrl_t   ctrl
);
  import uera_pkg::*;

  // Step addresses.
  localparam logic [UPC_W-1:0] A_FETCH = 6'd0;
  localparam logic [UPC_W-1:0] A_DISP  = 6'd1;
  localparam logic [UPC_W-1:0] A_ID0   = 6'd2;
  localparam logic [UPC_W-1:0] A_ID1   = 6'd3;
  localparam logic [UPC_W-1:0] A_ID2   = 6'd4;
  localparam logic [UPC_W-1:0] A_BG0   = 6'd5;
  localparam logic [UPC_W-1:0] A_BGL   = 6'd6;
  localparam logic [UPC_W-1:0] A_BGH   = 6'd7;
  localparam logic [UPC_W-1:0] A_TL0   = 6'd8;
  localparam logic [UPC_W-1:0] A_TL1   = 6'd9;
  localparam logic [UPC_W-1:0] A_TL2   = 6'd10;
  localparam logic [UPC_W-1:0] A_TH0   = 6'd11;
  localparam logic [UPC_W-1:0] A_TH1   = 6'd12;
  localparam logic [UPC_W-1:0] A_TH2   = 6'd13;
  localparam logic [UPC_W-1:0] A_FA0   = 6'd14;
  localparam logic [UPC_W-1:0] A_FA1   = 6'd15;
  localparam logic [UPC_W-1:0] A_FA2   = 6'd16;
  localparam logic [UPC_W-1:0] A_FA3   = 6'd17;
  localparam logic [UPC_W-1:0] A_FA4   = 6'd18;
  localparam logic [UPC_W-1:0] A_RS0   = 6'd19;
  localparam logic [UPC_W-1:0] A_RS1   = 6'd20;
  localparam logic [UPC_W-1:0] A_RS2   = 6'd21;
  localparam logic [UPC_W-1:0] A_RS3   = 6'd22;
  localparam logic [UPC_W-1:0] A_EN0   = 6'd23;
  localparam logic [UPC_W-1:0] A_EN1   = 6'd24;
  localparam logic [UPC_W-1:0] A_PA0   = 6'd25;
  localparam logic [UPC_W-1:0] A_PA1   = 6'd26;
  localparam logic [UPC_W-1:0] A_NX0   = 6'd27;
  localparam logic [UPC_W-1:0] A_NX1   = 6'd28;
  localparam logic [UPC_W-1:0] A_NX2   = 6'd29;
  localparam logic [UPC_W-1:0] A_NX3   = 6'd30;
  localparam logic [UPC_W-1:0] A_NX4   = 6'd31;
  localparam logic [UPC_W-1:0] A_RERR  = 6'd32;
  localparam logic [UPC_W-1:0] A_EMIT  = 6'd33;
  localparam logic [UPC_W-1:0] A_PUSH  = 6'd34;

  // Pack one control word.
  function automatic ctrl_t uc(input logic rdy, input tick_op_t t, input logic we,
                               input phase_t ph, input dp_op_t op, input jump_t jk,
                               input cond_t c, input logic inv,
                               input logic [UPC_W-1:0] tgt);
    ctrl_t w;
    w.in_rdy  = rdy;
    w.tick_op = t;
    w.ph_we   = we;
    w.ph_val  = ph;
    w.op      = op;
    w.jk      = jk;
    w.cond    = c;
    w.inv     = inv;
    w.target  = tgt;
    return w;
  endfunction

  // Control store.
  function automatic ctrl_t rom(input logic [UPC_W-1:0] a);
    ctrl_t w;
    case (a)
      // Wait for an item, then branch on the phase.
      A_FETCH: w = uc(1'b1, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_IN_FIRE, 1'b1, A_FETCH);
      A_DISP:  w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_DISPATCH, C_ALWAYS, 1'b0,
                      A_FETCH);
      // Idle: without a start request just report; else start a run, or report an empty one as an error.
      A_ID0:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_START, 1'b1, A_EMIT);
      A_ID1:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_COUNT_ZERO, 1'b0,
                      A_RERR);
      A_ID2:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_LOAD_RUN, JK_COND, C_ALWAYS, 1'b0,
                      A_BG0);
      // Start of a sample.
      A_BG0:   w = uc(1'b0, T_CLR, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_LOW_ZERO, 1'b0, A_BGH);
      A_BGL:   w = uc(1'b0, T_HOLD, 1'b1, PH_TLOW, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      A_BGH:   w = uc(1'b0, T_HOLD, 1'b1, PH_THIGH, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      // Trigger low.
      A_TL0:   w = uc(1'b0, T_INC, 1'b0, PH_IDLE, OP_NONE, JK_NEXT, C_ALWAYS, 1'b0, A_FETCH);
      A_TL1:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_GE_LOW, 1'b1, A_EMIT);
      A_TL2:   w = uc(1'b0, T_CLR, 1'b1, PH_THIGH, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      // Trigger high.
      A_TH0:   w = uc(1'b0, T_INC, 1'b0, PH_IDLE, OP_NONE, JK_NEXT, C_ALWAYS, 1'b0, A_FETCH);
      A_TH1:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_GE_HIGH, 1'b1, A_EMIT);
      A_TH2:   w = uc(1'b0, T_CLR, 1'b1, PH_RISE, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      // Timing the echo pulse.
      A_FA0:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_ECHO, 1'b0, A_FA3);
      A_FA1:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_MUL, JK_NEXT, C_ALWAYS, 1'b0, A_FETCH);
      A_FA2:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_ACCUM, JK_COND, C_ALWAYS, 1'b0, A_EN0);
      A_FA3:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_GE_TMO, 1'b0, A_EN0);
      A_FA4:   w = uc(1'b0, T_INC, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      // Waiting for the echo to rise.
      A_RS0:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_ECHO, 1'b1, A_RS2);
      A_RS1:   w = uc(1'b0, T_ONE, 1'b1, PH_FALL, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      A_RS2:   w = uc(1'b0, T_INC, 1'b0, PH_IDLE, OP_NONE, JK_NEXT, C_ALWAYS, 1'b0, A_FETCH);
      A_RS3:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_GE_TMO, 1'b1, A_EMIT);
      // End of a sample.
      A_EN0:   w = uc(1'b0, T_CLR, 1'b0, PH_IDLE, OP_REM_DEC, JK_COND, C_PAUSE_ZERO, 1'b0,
                      A_NX0);
      A_EN1:   w = uc(1'b0, T_HOLD, 1'b1, PH_PAUSE, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_EMIT);
      // Pause between samples.
      A_PA0:   w = uc(1'b0, T_INC, 1'b0, PH_IDLE, OP_NONE, JK_NEXT, C_ALWAYS, 1'b0, A_FETCH);
      A_PA1:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_GE_PAUSE, 1'b1, A_EMIT);
      // Next sample, or the final report.
      A_NX0:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_REM_NZ, 1'b0, A_BG0);
      A_NX1:   w = uc(1'b0, T_CLR, 1'b1, PH_IDLE, OP_NONE, JK_COND, C_VALID_ZERO, 1'b0,
                      A_RERR);
      A_NX2:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_DIV_START, JK_NEXT, C_ALWAYS, 1'b0,
                      A_FETCH);
      A_NX3:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_DIV_BUSY, 1'b0, A_NX3);
      A_NX4:   w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_REP_AVG, JK_COND, C_ALWAYS, 1'b0,
                      A_EMIT);
      A_RERR:  w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_REP_ERR, JK_NEXT, C_ALWAYS, 1'b0,
                      A_FETCH);
      // Hand the result to the output register once it is free.
      A_EMIT:  w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_OUT_FULL, 1'b0, A_EMIT);
      A_PUSH:  w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_PUSH, JK_COND, C_ALWAYS, 1'b0, A_FETCH);
      default: w = uc(1'b0, T_HOLD, 1'b0, PH_IDLE, OP_NONE, JK_COND, C_ALWAYS, 1'b0, A_FETCH);
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             cond_raw;
  logic             cond_hit;
  logic [UPC_W-1:0] disp_addr;

  assign ctrl = rom(upc_r);

  // Condition select.
  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:     cond_raw = 1'b1;
      C_IN_FIRE:    cond_raw = status.in_fire;
      C_START:      cond_raw = status.start;
      C_COUNT_ZERO: cond_raw = status.count_zero;
      C_LOW_ZERO:   cond_raw = status.low_zero;
      C_GE_LOW:     cond_raw = status.ge_low;
      C_GE_HIGH:    cond_raw = status.ge_high;
      C_ECHO:       cond_raw = status.echo;
      C_GE_TMO:     cond_raw = status.ge_tmo;
      C_PAUSE_ZERO: cond_raw = status.pause_zero;
      C_GE_PAUSE:   cond_raw = status.ge_pause;
      C_REM_NZ:     cond_raw = status.rem_nz;
      C_VALID_ZERO: cond_raw = status.valid_zero;
      C_DIV_BUSY:   cond_raw = status.div_busy;
      C_OUT_FULL:   cond_raw = status.out_full;
      default:      cond_raw = 1'b0;
    endcase
    cond_hit = cond_raw ^ ctrl.inv;
  end

  // Entry point of each phase's routine.
  always_comb begin
    case (status.phase)
      PH_IDLE:  disp_addr = A_ID0;
      PH_TLOW:  disp_addr = A_TL0;
      PH_THIGH: disp_addr = A_TH0;
      PH_RISE:  disp_addr = A_RS0;
      PH_FALL:  disp_addr = A_FA0;
      PH_PAUSE: disp_addr = A_PA0;
      default:  disp_addr = A_ID0;
    endcase
  end

  // Step counter.
  always_comb begin
    case (ctrl.jk)
      JK_NEXT:     upc_nxt = upc_r + UPC_W'(1);
      JK_COND:     upc_nxt = cond_hit ? ctrl.target : upc_r + UPC_W'(1);
      JK_DISPATCH: upc_nxt = disp_addr;
      default:     upc_nxt = A_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= A_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire
